>>> rtl/core/tlu_pkg.sv
// ============================================================================
// tlu_pkg: shared types and constants of the tridiagonal LU solver
// Holds row and result item types, the queue entry type and the mode codes.
// ============================================================================
package tlu_pkg;

    // Store depth and derived widths.
    localparam int MAX_ROWS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int IDX_OUT_W = 6;

    // Data widths.
    localparam int DATA_W    = 32;
    localparam int GROWTH_W  = 17;
    localparam int FRAC_W    = 16;
    localparam int DIV_NUM_W = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Solve mode codes.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FACTOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUBST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower_coef;
        logic signed [DATA_W-1:0] diag_coef;
        logic signed [DATA_W-1:0] upper_coef;
        logic signed [DATA_W-1:0] rhs_value;
        logic                     last_row;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]     row_index;
        logic signed [DATA_W-1:0] multiplier_out;
        logic signed [DATA_W-1:0] pivot_out;
        logic signed [DATA_W-1:0] solution_out;
        logic [GROWTH_W-1:0]      growth_out;
        logic                     status;
        logic                     last_result;
    } result_t;

    // One classified item as it travels from front to back.
    typedef struct packed {
        in_item_t          item;
        logic              store_en;
        logic [ROW_W-1:0]  idx;
        logic [CNT_W-1:0]  n_rows;
        logic [DATA_W-1:0] s1_mag;
    } row_entry_t;

    // Magnitude of a signed word; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        begin
            r = v[DATA_W-1] ? (DATA_W'(0) - DATA_W'(v)) : DATA_W'(v);
            return r;
        end
    endfunction

endpackage

>>> rtl/core/tlu_front.sv
// ============================================================================
// tlu_front: row intake and classification
// Counts stored rows, tracks the largest input magnitude and pushes each
// accepted item with its store slot and run totals into the queue.
// ============================================================================
module tlu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tlu_pkg::in_item_t    in_data,
    output logic                 q_push,
    output tlu_pkg::row_entry_t  q_entry,
    input  logic                 q_full
);

    logic [tlu_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tlu_pkg::DATA_W-1:0] max_reg, max_next;
    logic [tlu_pkg::DATA_W-1:0] prev_umag_reg, prev_umag_next;

    logic                       store;
    logic                       accept;
    logic [tlu_pkg::DATA_W-1:0] mag_d;
    logic [tlu_pkg::DATA_W-1:0] mag_l;
    logic [tlu_pkg::DATA_W-1:0] mx;
    logic [tlu_pkg::CNT_W-1:0]  n_val;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Running maximum over diagonal, lower and the previous row's upper.
    always_comb
    begin
        store = (cnt_reg < tlu_pkg::CNT_W'(tlu_pkg::MAX_ROWS));
        mag_d = tlu_pkg::mag32(in_data.diag_coef);
        mag_l = tlu_pkg::mag32(in_data.lower_coef);
        mx    = max_reg;
        if (mag_d > mx)
        begin
            mx = mag_d;
        end
        if (cnt_reg != '0)
        begin
            if (mag_l > mx)
            begin
                mx = mag_l;
            end
            if (prev_umag_reg > mx)
            begin
                mx = prev_umag_reg;
            end
        end
        if (!store)
        begin
            mx = max_reg;
        end
        n_val = store ? (cnt_reg + tlu_pkg::CNT_W'(1)) : cnt_reg;

        q_entry.item     = in_data;
        q_entry.store_en = store;
        q_entry.idx      = cnt_reg[tlu_pkg::ROW_W-1:0];
        q_entry.n_rows   = n_val;
        q_entry.s1_mag   = mx;
    end

    // The last row of a system clears the count and maximum for the next one.
    always_comb
    begin
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        prev_umag_next = prev_umag_reg;
        if (accept)
        begin
            if (in_data.last_row)
            begin
                cnt_next = '0;
                max_next = '0;
            end
            else
            begin
                cnt_next = n_val;
                max_next = mx;
            end
            if (store)
            begin
                prev_umag_next = tlu_pkg::mag32(in_data.upper_coef);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            max_reg       <= '0;
            prev_umag_reg <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            max_reg       <= max_next;
            prev_umag_reg <= prev_umag_next;
        end
    end

endmodule

>>> rtl/core/tlu_queue.sv
// ============================================================================
// tlu_queue: short queue between front and back
// Two-entry first-in first-out buffer of classified row items.
// ============================================================================
module tlu_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlu_pkg::row_entry_t  push_entry,
    output logic                 full,
    input  logic                 pop,
    output tlu_pkg::row_entry_t  head_entry,
    output logic                 empty
);

    tlu_pkg::row_entry_t         slot_reg [tlu_pkg::QUEUE_DEPTH];
    logic [tlu_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tlu_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tlu_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full       = (count_reg == tlu_pkg::QCNT_W'(tlu_pkg::QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + tlu_pkg::QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + tlu_pkg::QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + tlu_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - tlu_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/tlu_div.sv
// ============================================================================
// tlu_div: iterative unsigned divider
// Restoring division of a 48-bit numerator by a 32-bit divisor, one
// quotient bit per cycle; done pulses for one cycle when quo is valid.
// ============================================================================
module tlu_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tlu_pkg::DIV_NUM_W-1:0]   num,
    input  logic [tlu_pkg::DATA_W-1:0]      den,
    output logic                            done,
    output logic [tlu_pkg::DIV_NUM_W-1:0]   quo
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [tlu_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [tlu_pkg::DATA_W-1:0]      rem_reg, rem_next;
    logic [tlu_pkg::DATA_W-1:0]      den_reg, den_next;
    logic [tlu_pkg::DIV_NUM_W-1:0]   quo_reg, quo_next;

    logic [tlu_pkg::DATA_W:0]        trial;
    logic [tlu_pkg::DATA_W:0]        diff;
    logic                            ge;

    assign done = done_reg;
    assign quo  = quo_reg;

    // One trial subtraction per cycle; numerator bits shift out as quotient
    // bits shift in.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[tlu_pkg::DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = tlu_pkg::DIV_CNT_W'(tlu_pkg::DIV_NUM_W - 1);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[tlu_pkg::DATA_W-1:0] : trial[tlu_pkg::DATA_W-1:0];
            quo_next = {quo_reg[tlu_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - tlu_pkg::DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
        end
    end

endmodule

>>> rtl/core/tlu_back.sv
// ============================================================================
// tlu_back: row stores and run sequencer
// Writes rows into the stores; in modes other than none it factorizes and/or
// substitutes and emits one result per row, or one error item on a zero pivot.
// ============================================================================
module tlu_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlu_pkg::MODE_W-1:0]    solve_mode,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  tlu_pkg::row_entry_t           q_entry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tlu_pkg::result_t              out_data
);

    localparam int DW = tlu_pkg::DATA_W;
    localparam int PW = tlu_pkg::DIV_NUM_W;
    localparam int RW = tlu_pkg::ROW_W;
    localparam int CW = tlu_pkg::CNT_W;
    localparam int SW = 5;

    localparam logic [SW-1:0] S_IDLE     = 5'd0;
    localparam logic [SW-1:0] S_FZ_RD0   = 5'd1;
    localparam logic [SW-1:0] S_FZ_CHK0  = 5'd2;
    localparam logic [SW-1:0] S_FZ_RD    = 5'd3;
    localparam logic [SW-1:0] S_FZ_DIV   = 5'd4;
    localparam logic [SW-1:0] S_FZ_WAIT  = 5'd5;
    localparam logic [SW-1:0] S_FZ_MUL   = 5'd6;
    localparam logic [SW-1:0] S_FZ_SUB   = 5'd7;
    localparam logic [SW-1:0] S_FZ_WR    = 5'd8;
    localparam logic [SW-1:0] S_GR_START = 5'd9;
    localparam logic [SW-1:0] S_GR_WAIT  = 5'd10;
    localparam logic [SW-1:0] S_SV_RD0   = 5'd11;
    localparam logic [SW-1:0] S_SV_LD0   = 5'd12;
    localparam logic [SW-1:0] S_FW_RD    = 5'd13;
    localparam logic [SW-1:0] S_FW_MUL   = 5'd14;
    localparam logic [SW-1:0] S_FW_SUB   = 5'd15;
    localparam logic [SW-1:0] S_BK_RDL   = 5'd16;
    localparam logic [SW-1:0] S_BK_DIV   = 5'd17;
    localparam logic [SW-1:0] S_BK_WAIT  = 5'd18;
    localparam logic [SW-1:0] S_BK_WR    = 5'd19;
    localparam logic [SW-1:0] S_BK_RD    = 5'd20;
    localparam logic [SW-1:0] S_BK_MUL   = 5'd21;
    localparam logic [SW-1:0] S_BK_SUB   = 5'd22;
    localparam logic [SW-1:0] S_OUT_RD   = 5'd23;
    localparam logic [SW-1:0] S_OUT_PUSH = 5'd24;
    localparam logic [SW-1:0] S_ERR      = 5'd25;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // Signed quotient from magnitude and sign, saturated to 32 bits.
    function automatic logic signed [DW-1:0] sat_div(input logic [PW-1:0] mag,
                                                     input logic neg);
        logic signed [DW-1:0] r;
        begin
            if (!neg)
            begin
                r = (mag > PW'(SMAX)) ? SMAX : DW'(mag);
            end
            else
            begin
                r = (mag > PW'({1'b0, SMIN})) ? SMIN : (DW'(0) - mag[DW-1:0]);
            end
            return r;
        end
    endfunction

    // Q16.16 product, floor of the exact product over 2^16.
    function automatic logic signed [PW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [2*DW-1:0] p;
        begin
            p = a * b;
            return p[2*DW-1:tlu_pkg::FRAC_W];
        end
    endfunction

    // a - b saturated to 32-bit signed.
    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [PW-1:0] b);
        logic signed [PW:0] d;
        logic signed [DW-1:0] r;
        begin
            d = {{(PW-DW+1){a[DW-1]}}, a} - {b[PW-1], b};
            if (!d[PW] && (d[PW-1:DW-1] != '0))
            begin
                r = SMAX;
            end
            else if (d[PW] && (d[PW-1:DW-1] != '1))
            begin
                r = SMIN;
            end
            else
            begin
                r = d[DW-1:0];
            end
            return r;
        end
    endfunction

    // Row stores.
    logic signed [DW-1:0] l_mem [tlu_pkg::MAX_ROWS];
    logic signed [DW-1:0] d_mem [tlu_pkg::MAX_ROWS];
    logic signed [DW-1:0] u_mem [tlu_pkg::MAX_ROWS];
    logic [DW:0]          r_mem [tlu_pkg::MAX_ROWS];

    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic [RW-1:0]        wr_addr;
    logic                 l_we, d_we, u_we, r_we;
    logic signed [DW-1:0] l_wd, d_wd, u_wd;
    logic [DW:0]          r_wd;
    logic signed [DW-1:0] l_q, d_q, u_q;
    logic [DW:0]          r_q;

    // Sequencer registers.
    logic [SW-1:0]        state_reg, state_next;
    logic [RW-1:0]        i_reg, i_next;
    logic [CW-1:0]        n_reg, n_next;
    logic                 fz_reg, fz_next;
    logic                 sol_reg, sol_next;
    logic [DW-1:0]        s1_reg, s1_next;
    logic [DW-1:0]        s2_reg, s2_next;
    logic signed [DW-1:0] prev_d_reg, prev_d_next;
    logic signed [DW-1:0] prev_u_reg, prev_u_next;
    logic signed [DW-1:0] m_reg, m_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [DW-1:0] dn_reg, dn_next;
    logic signed [DW-1:0] prev_r_reg, prev_r_next;
    logic signed [DW-1:0] t_reg, t_next;
    logic signed [DW-1:0] q_reg, q_next;
    logic                 flag_reg, flag_next;
    logic                 neg_reg, neg_next;
    logic [tlu_pkg::GROWTH_W-1:0] growth_reg, growth_next;
    logic                 out_valid_reg, out_valid_next;
    tlu_pkg::result_t     out_data_reg, out_data_next;

    // Divider hookup.
    logic                 div_start;
    logic [PW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic                 div_done;
    logic [PW-1:0]        div_quo;

    logic                 out_free;
    logic                 at_last;
    logic [RW-1:0]        last_idx;
    logic [DW-1:0]        dn_mag;
    logic [DW-1:0]        d0_mag;
    logic signed [DW-1:0] rn;

    tlu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign at_last   = ({1'b0, i_reg} == (n_reg - CW'(1)));
    assign last_idx  = RW'(n_reg - CW'(1));
    assign dn_mag    = tlu_pkg::mag32(dn_reg);
    assign d0_mag    = tlu_pkg::mag32(d_q);
    assign rn        = sat_sub($signed(r_q[DW-1:0]), prod_reg);

    // Store write and registered read ports.
    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[wr_addr] <= l_wd;
        end
        if (d_we)
        begin
            d_mem[wr_addr] <= d_wd;
        end
        if (u_we)
        begin
            u_mem[wr_addr] <= u_wd;
        end
        if (r_we)
        begin
            r_mem[wr_addr] <= r_wd;
        end
        if (rd_en)
        begin
            l_q <= l_mem[rd_addr];
            d_q <= d_mem[rd_addr];
            u_q <= u_mem[rd_addr];
            r_q <= r_mem[rd_addr];
        end
    end

    // Run sequencer.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        fz_next        = fz_reg;
        sol_next       = sol_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        prev_d_next    = prev_d_reg;
        prev_u_next    = prev_u_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        dn_next        = dn_reg;
        prev_r_next    = prev_r_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        flag_next      = flag_reg;
        neg_next       = neg_reg;
        growth_next    = growth_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        q_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = i_reg;
        wr_addr   = i_reg;
        l_we      = 1'b0;
        d_we      = 1'b0;
        u_we      = 1'b0;
        r_we      = 1'b0;
        l_wd      = m_reg;
        d_wd      = dn_reg;
        u_wd      = q_entry.item.upper_coef;
        r_wd      = {flag_reg, q_reg};
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        unique case (state_reg)
            // Store rows; the last one starts a run unless the mode is none.
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_entry.store_en)
                    begin
                        wr_addr = q_entry.idx;
                        l_we    = 1'b1;
                        d_we    = 1'b1;
                        u_we    = 1'b1;
                        r_we    = 1'b1;
                        l_wd    = q_entry.item.lower_coef;
                        d_wd    = q_entry.item.diag_coef;
                        r_wd    = {1'b0, q_entry.item.rhs_value};
                    end
                    if (q_entry.item.last_row)
                    begin
                        n_next   = q_entry.n_rows;
                        s1_next  = q_entry.s1_mag;
                        fz_next  = (solve_mode == tlu_pkg::MODE_FACTOR) ||
                                   (solve_mode == tlu_pkg::MODE_BOTH);
                        sol_next = (solve_mode == tlu_pkg::MODE_SUBST) ||
                                   (solve_mode == tlu_pkg::MODE_BOTH);
                        i_next   = '0;
                        if (solve_mode == tlu_pkg::MODE_NONE)
                        begin
                            state_next = S_IDLE;
                        end
                        else if ((solve_mode == tlu_pkg::MODE_FACTOR) ||
                                 (solve_mode == tlu_pkg::MODE_BOTH))
                        begin
                            state_next = S_FZ_RD0;
                        end
                        else
                        begin
                            state_next = S_SV_RD0;
                        end
                    end
                end
            end

            // Factorization: first pivot.
            S_FZ_RD0:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_FZ_CHK0;
            end
            S_FZ_CHK0:
            begin
                if (d_q == '0)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    prev_d_next = d_q;
                    prev_u_next = u_q;
                    s2_next     = (d0_mag > s1_reg) ? d0_mag : s1_reg;
                    i_next      = RW'(1);
                    state_next  = (n_reg == CW'(1)) ? S_GR_START : S_FZ_RD;
                end
            end

            // Factorization: multiplier, then pivot.
            S_FZ_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_FZ_DIV;
            end
            S_FZ_DIV:
            begin
                div_start  = 1'b1;
                div_num    = {tlu_pkg::mag32(l_q), {tlu_pkg::FRAC_W{1'b0}}};
                div_den    = tlu_pkg::mag32(prev_d_reg);
                neg_next   = l_q[DW-1] ^ prev_d_reg[DW-1];
                state_next = S_FZ_WAIT;
            end
            S_FZ_WAIT:
            begin
                if (div_done)
                begin
                    m_next     = sat_div(div_quo, neg_reg);
                    state_next = S_FZ_MUL;
                end
            end
            S_FZ_MUL:
            begin
                prod_next  = mulq(m_reg, prev_u_reg);
                state_next = S_FZ_SUB;
            end
            S_FZ_SUB:
            begin
                dn_next    = sat_sub(d_q, prod_reg);
                state_next = S_FZ_WR;
            end
            S_FZ_WR:
            begin
                l_we = 1'b1;
                d_we = 1'b1;
                if (dn_reg == '0)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    prev_d_next = dn_reg;
                    prev_u_next = u_q;
                    if (dn_mag > s2_reg)
                    begin
                        s2_next = dn_mag;
                    end
                    if (at_last)
                    begin
                        state_next = S_GR_START;
                    end
                    else
                    begin
                        i_next     = i_reg + RW'(1);
                        state_next = S_FZ_RD;
                    end
                end
            end

            // Growth value.
            S_GR_START:
            begin
                if (s2_reg == '0)
                begin
                    growth_next = '0;
                    i_next      = '0;
                    state_next  = sol_reg ? S_SV_RD0 : S_OUT_RD;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {s1_reg, {tlu_pkg::FRAC_W{1'b0}}};
                    div_den    = s2_reg;
                    state_next = S_GR_WAIT;
                end
            end
            S_GR_WAIT:
            begin
                if (div_done)
                begin
                    growth_next = div_quo[tlu_pkg::GROWTH_W-1:0];
                    i_next      = '0;
                    state_next  = sol_reg ? S_SV_RD0 : S_OUT_RD;
                end
            end

            // Forward substitution.
            S_SV_RD0:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_SV_LD0;
            end
            S_SV_LD0:
            begin
                prev_r_next = $signed(r_q[DW-1:0]);
                i_next      = RW'(1);
                state_next  = (n_reg == CW'(1)) ? S_BK_RDL : S_FW_RD;
            end
            S_FW_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_FW_MUL;
            end
            S_FW_MUL:
            begin
                prod_next  = mulq(l_q, prev_r_reg);
                state_next = S_FW_SUB;
            end
            S_FW_SUB:
            begin
                r_we        = 1'b1;
                r_wd        = {1'b0, rn};
                prev_r_next = rn;
                if (at_last)
                begin
                    state_next = S_BK_RDL;
                end
                else
                begin
                    i_next     = i_reg + RW'(1);
                    state_next = S_FW_RD;
                end
            end

            // Back substitution, from the last row up.
            S_BK_RDL:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx;
                i_next     = last_idx;
                t_next     = prev_r_reg;
                state_next = S_BK_DIV;
            end
            S_BK_DIV:
            begin
                if (d_q == '0)
                begin
                    flag_next = 1'b1;
                    if (t_reg == '0)
                    begin
                        q_next = '0;
                    end
                    else
                    begin
                        q_next = t_reg[DW-1] ? SMIN : SMAX;
                    end
                    state_next = S_BK_WR;
                end
                else
                begin
                    flag_next  = 1'b0;
                    div_start  = 1'b1;
                    div_num    = {tlu_pkg::mag32(t_reg), {tlu_pkg::FRAC_W{1'b0}}};
                    div_den    = tlu_pkg::mag32(d_q);
                    neg_next   = t_reg[DW-1] ^ d_q[DW-1];
                    state_next = S_BK_WAIT;
                end
            end
            S_BK_WAIT:
            begin
                if (div_done)
                begin
                    q_next     = sat_div(div_quo, neg_reg);
                    state_next = S_BK_WR;
                end
            end
            S_BK_WR:
            begin
                r_we = 1'b1;
                if (i_reg == '0)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    i_next     = i_reg - RW'(1);
                    state_next = S_BK_RD;
                end
            end
            S_BK_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_BK_MUL;
            end
            S_BK_MUL:
            begin
                prod_next  = mulq(u_q, q_reg);
                state_next = S_BK_SUB;
            end
            S_BK_SUB:
            begin
                t_next     = rn;
                state_next = S_BK_DIV;
            end

            // Result items, one per row in order.
            S_OUT_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_OUT_PUSH;
            end
            S_OUT_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.row_index      = tlu_pkg::IDX_OUT_W'(i_reg);
                    out_data_next.multiplier_out = (i_reg == '0) ? '0 : l_q;
                    out_data_next.pivot_out      = d_q;
                    out_data_next.solution_out   = sol_reg ? $signed(r_q[DW-1:0]) : '0;
                    out_data_next.growth_out     = fz_reg ? growth_reg : '0;
                    out_data_next.status         = sol_reg && r_q[DW];
                    out_data_next.last_result    = at_last;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + RW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end

            // Zero pivot: a single error item.
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next                = '0;
                    out_data_next.row_index      = tlu_pkg::IDX_OUT_W'(i_reg);
                    out_data_next.status         = 1'b1;
                    out_data_next.last_result    = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            n_reg         <= '0;
            fz_reg        <= 1'b0;
            sol_reg       <= 1'b0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            prev_d_reg    <= '0;
            prev_u_reg    <= '0;
            m_reg         <= '0;
            prod_reg      <= '0;
            dn_reg        <= '0;
            prev_r_reg    <= '0;
            t_reg         <= '0;
            q_reg         <= '0;
            flag_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            growth_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
            fz_reg        <= fz_next;
            sol_reg       <= sol_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            prev_d_reg    <= prev_d_next;
            prev_u_reg    <= prev_u_next;
            m_reg         <= m_next;
            prod_reg      <= prod_next;
            dn_reg        <= dn_next;
            prev_r_reg    <= prev_r_next;
            t_reg         <= t_next;
            q_reg         <= q_next;
            flag_reg      <= flag_next;
            neg_reg       <= neg_next;
            growth_reg    <= growth_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

>>> rtl/core/tridiagonal_lu_solver_core.sv
// ============================================================================
// tridiagonal_lu_solver_core: tridiagonal system solver, Q16.16
// Loads rows, then factorizes and/or solves by forward and back substitution
// in the mode set; returns one item per row or one error item, none in mode 0.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      in_valid / in_ready          tlu_pkg::in_item_t
//   out       output     out_valid / out_ready        tlu_pkg::result_t
//   cfg       input      cfg_wr_en (no wait)          solve_mode, 2 bits
//
// A row that does not end a system is stored without the back end leaving idle.
// Each factorized row and each back-substituted row waits on the bit-serial
// divider for its quotient, as does the growth value; output reads each row
// from the stores before offering it.
// Reset is asynchronous; solve_mode resets to 3 and all stores need no clear.
// A stalled output holds the sequencer; the input side keeps taking items
// into the two-entry queue until it is full.
// ============================================================================
module tridiagonal_lu_solver_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tlu_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tlu_pkg::result_t              out_data,
    input  logic                          cfg_wr_en,
    input  logic [tlu_pkg::MODE_W-1:0]    cfg_wr_data
);

    logic [tlu_pkg::MODE_W-1:0] solve_mode_reg, solve_mode_next;
    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    tlu_pkg::row_entry_t        push_entry;
    tlu_pkg::row_entry_t        head_entry;

    // Mode register.
    assign solve_mode_next = cfg_wr_en ? cfg_wr_data : solve_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solve_mode_reg <= tlu_pkg::MODE_BOTH;
        end
        else
        begin
            solve_mode_reg <= solve_mode_next;
        end
    end

    tlu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_entry  (push_entry),
        .q_full   (q_full)
    );

    tlu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_entry (head_entry),
        .empty      (q_empty)
    );

    tlu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .solve_mode (solve_mode_reg),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_entry    (head_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

>>> rtl/core/tlu_checker.sv
// ============================================================================
// tlu_checker: port-level checks of the solver
// Watches the result channel for hold behavior and value consistency.
// ============================================================================
module tlu_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             out_valid,
    input  logic             out_ready,
    input  tlu_pkg::result_t out_data
);

    // A pending result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before acceptance");

    // Growth never exceeds one in Q16.16.
    a_growth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.growth_out <= 17'd65536))
        else $error("growth value out of range");

    // A zero pivot always comes with an error status.
    a_zero_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.pivot_out == '0) |-> out_data.status)
        else $error("zero pivot reported without status");

endmodule

bind tridiagonal_lu_solver_core tlu_checker u_tlu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
